### hw/rtl/erff_pkg.sv
`default_nettype none

package erff_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int GAMMA_W   = 27;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 27'd27962027;

  // one quotient bit per divider step, two radicand bits per root step
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int SQ_STEPS  = (64 + FRAC_BITS + 1) / 2;

  // input reg, two 2-stage multiplies, divider, multiply, root, multiply, output reg
  // (divider and root each add one register for their operands)
  localparam int DEPTH = 12 + DIV_STEPS + SQ_STEPS;

  typedef logic signed [63:0] fx_t;

  localparam fx_t LIM    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t ONE_FX = 64'sd1 <<< FRAC_BITS;

endpackage

`default_nettype wire

### hw/rtl/erff_if.sv
`default_nettype none

interface erff_face_if;
  import erff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] dens_left;
  logic signed [DATA_W-1:0] dens_right;
  logic signed [DATA_W-1:0] velx_left;
  logic signed [DATA_W-1:0] velx_right;
  logic signed [DATA_W-1:0] vely_left;
  logic signed [DATA_W-1:0] vely_right;
  logic signed [DATA_W-1:0] press_left;
  logic signed [DATA_W-1:0] press_right;

  modport source (
    output valid, dens_left, dens_right, velx_left, velx_right,
           vely_left, vely_right, press_left, press_right,
    input  ready
  );

  modport sink (
    input  valid, dens_left, dens_right, velx_left, velx_right,
           vely_left, vely_right, press_left, press_right,
    output ready
  );
endinterface

interface erff_flux_if;
  import erff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mass_flux;
  logic signed [DATA_W-1:0] momx_flux;
  logic signed [DATA_W-1:0] momy_flux;
  logic signed [DATA_W-1:0] energy_flux;
  logic                     bad_state;
  logic                     saturated;

  modport source (
    output valid, mass_flux, momx_flux, momy_flux, energy_flux, bad_state, saturated,
    input  ready
  );

  modport sink (
    input  valid, mass_flux, momx_flux, momy_flux, energy_flux, bad_state, saturated,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/euler_rusanov_face_flux.sv
`default_nettype none
// Rusanov face flux, 2-D Euler, ideal gas, signed Q8.24.
// A face word runs through the input register, two multiplies, the 88-step divider,
//   a multiply, the 44-step root, a multiply and the output register.
// Throughput: one face word per cycle; a stall on the flux side freezes the
//   whole pipeline for that cycle.
// Reset (rst, synchronous): empties the pipeline, gamma back to about 5/3.
module euler_rusanov_face_flux (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [erff_pkg::GAMMA_W-1:0]  cfg_wdata,
  erff_face_if.sink                     face,
  erff_flux_if.source                   flux
);
  import erff_pkg::*;

  // ---------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------
  // 64x64 product as four 32x32 partial products
  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } mpp_t;

  // restoring divider lane, one quotient bit per stage
  typedef struct packed {
    logic                 neg;
    logic                 over;
    logic [63:0]          ub;
    logic [63:0]          rem;
    logic [63:0]          q;
    logic [DIV_STEPS-1:0] num;
  } dl_t;

  // digit-by-digit square root lane, two radicand bits per stage
  typedef struct packed {
    logic [2*SQ_STEPS-1:0] num;
    logic [SQ_STEPS+1:0]   rem;
    logic [SQ_STEPS-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rl;
    logic signed [DATA_W-1:0] rr;
    logic signed [DATA_W-1:0] ul;
    logic signed [DATA_W-1:0] ur;
    logic signed [DATA_W-1:0] wl;
    logic signed [DATA_W-1:0] wr;
    logic signed [DATA_W-1:0] pl;
    logic signed [DATA_W-1:0] pr;
  } in_t;

  typedef struct packed {
    logic bad;
    fx_t  gm1, rl, rr, ul, ur, pl, pr;
  } c1_t;

  typedef struct packed {
    logic bad;
    fx_t  gm1, rl, rr, ul, ur, pl, pr, gpl, gpr, mx, my, rs, dmx, dmy;
  } c3_t;

  typedef struct packed {
    logic bad;
    fx_t  gm1, rl, rr, ul, ur, mx, dmx, dmy, hkl, hkr;
  } c5_t;

  typedef struct packed {
    logic bad;
    fx_t  rl, rr, ul, ur, mx, dmx, dmy, de, es, dvx, dfx, dfy;
  } c6_t;

  typedef struct packed {
    logic bad;
    fx_t  rl, rr, ul, ur, mx, dmx, dmy, de, dvx, dfy, fxc, ese;
  } c8_t;

  typedef struct packed {
    logic bad;
    fx_t  mx, fxc, dfy;
  } c9_t;

  // product slots, first multiply
  localparam int M_UUL = 0, M_WWL = 1, M_UUR = 2, M_WWR = 3, M_MXL = 4;
  localparam int M_MXR = 5, M_MYL = 6, M_MYR = 7, M_GPL = 8, M_GPR = 9;
  // second multiply
  localparam int N_RKL = 0, N_RKR = 1, N_MXX = 2, N_MYY = 3, N_MXY = 4;
  // divider lanes
  localparam int D_EPL = 0, D_EPR = 1, D_SSL = 2, D_SSR = 3;
  localparam int D_VX  = 4, D_FX  = 5, D_FY  = 6, D_Q   = 7;
  // dissipation and energy-flux multiply
  localparam int H_RHO = 0, H_MX = 1, H_MY = 2, H_EN = 3, H_FE = 4;

  // ---------------------------------------------------------------------
  // Arithmetic helpers (saturate at +-(2^63-1), truncate toward zero)
  // ---------------------------------------------------------------------
  function automatic fx_t sx(logic signed [DATA_W-1:0] x);
    return {{(64-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  function automatic logic [63:0] mag(fx_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic fx_t sadd(fx_t a, fx_t b);
    logic signed [64:0] s;
    logic signed [64:0] top;
    s   = {a[63], a} + {b[63], b};
    top = {LIM[63], LIM};
    if (s > top) return LIM;
    if (s < -top) return -LIM;
    return s[63:0];
  endfunction

  function automatic fx_t ssub(fx_t a, fx_t b);
    return sadd(a, -b);
  endfunction

  // product with 0.5: magnitude shifted right by one
  function automatic fx_t half(fx_t a);
    logic [63:0] m;
    m = mag(a) >> 1;
    return a[63] ? -fx_t'(m) : fx_t'(m);
  endfunction

  function automatic fx_t sabs(fx_t a);
    return a[63] ? -a : a;
  endfunction

  function automatic mpp_t mul_pp(fx_t a, fx_t b);
    mpp_t        r;
    logic [63:0] ua;
    logic [63:0] ub;
    ua    = mag(a);
    ub    = mag(b);
    r.neg = a[63] ^ b[63];
    r.p00 = 64'(ua[31:0])  * 64'(ub[31:0]);
    r.p01 = 64'(ua[31:0])  * 64'(ub[63:32]);
    r.p10 = 64'(ua[63:32]) * 64'(ub[31:0]);
    r.p11 = 64'(ua[63:32]) * 64'(ub[63:32]);
    return r;
  endfunction

  function automatic fx_t mul_fin(mpp_t m);
    logic [127:0] full;
    logic [63:0]  q;
    full = {m.p11, 64'd0} + {32'd0, m.p01, 32'd0} + {32'd0, m.p10, 32'd0}
         + {64'd0, m.p00};
    q    = full[FRAC_BITS+63:FRAC_BITS];
    if ((|full[127:FRAC_BITS+64]) || q[63]) return m.neg ? -LIM : LIM;
    return m.neg ? -fx_t'(q) : fx_t'(q);
  endfunction

  function automatic dl_t div_init(fx_t a, fx_t b);
    dl_t r;
    r.neg  = a[63] ^ b[63];
    r.over = 1'b0;
    r.ub   = mag(b);
    r.rem  = '0;
    r.q    = '0;
    r.num  = {mag(a), {FRAC_BITS{1'b0}}};
    return r;
  endfunction

  function automatic dl_t div_step(dl_t d);
    dl_t         r;
    logic [64:0] rs;
    logic [64:0] df;
    logic        ge;
    rs     = {d.rem, d.num[DIV_STEPS-1]};
    df     = rs - {1'b0, d.ub};
    ge     = rs >= {1'b0, d.ub};
    r      = d;
    r.rem  = ge ? df[63:0] : rs[63:0];
    r.num  = d.num << 1;
    r.over = d.over | d.q[63];
    r.q    = {d.q[62:0], ge};
    return r;
  endfunction

  function automatic fx_t div_fin(dl_t d);
    if (d.over || d.q[63]) return d.neg ? -LIM : LIM;
    return d.neg ? -fx_t'(d.q) : fx_t'(d.q);
  endfunction

  function automatic sq_t sq_init(fx_t a);
    sq_t r;
    r.rem  = '0;
    r.root = '0;
    if (a > fx_t'(0)) begin
      r.num = (2*SQ_STEPS)'({a, {FRAC_BITS{1'b0}}});
    end else begin
      r.num = '0;
    end
    return r;
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t                 r;
    logic [SQ_STEPS+3:0] rs;
    logic [SQ_STEPS+3:0] tr;
    logic [SQ_STEPS+3:0] df;
    logic                ge;
    rs     = {s.rem, s.num[2*SQ_STEPS-1 -: 2]};
    tr     = {2'b00, s.root, 2'b01};
    df     = rs - tr;
    ge     = rs >= tr;
    r.rem  = ge ? df[SQ_STEPS+1:0] : rs[SQ_STEPS+1:0];
    r.root = {s.root[SQ_STEPS-2:0], ge};
    r.num  = s.num << 2;
    return r;
  endfunction

  // {clipped flag, 32-bit value}
  function automatic logic [DATA_W:0] clip(fx_t v);
    if (v > 64'sd2147483647) return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    if (v < -64'sd2147483648) return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  // ---------------------------------------------------------------------
  // Config register and flow control
  // ---------------------------------------------------------------------
  logic [GAMMA_W-1:0] gamma;
  logic [DEPTH-1:0]   vld;
  logic               adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_we) begin
      gamma <= cfg_wdata;
    end
  end

  // whole pipeline moves unless the output word is held
  assign adv        = !vld[DEPTH-1] || flux.ready;
  assign face.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], face.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------
  in_t  s0;
  c1_t  s1c, s2c, c1n;
  mpp_t s1m [10];
  mpp_t m1n [10];
  fx_t  s2v [10];
  c3_t  s3c, s4c, c3n;
  mpp_t s3m [5];
  mpp_t m3n [5];
  fx_t  s4v [5];
  c5_t  dpc [DIV_STEPS+1];
  dl_t  dpl [DIV_STEPS+1][8];
  c5_t  c5n;
  dl_t  d5n [8];
  fx_t  dr  [8];
  c6_t  s6c, s7c, c6n;
  mpp_t s6m, m6n;
  fx_t  s7p;
  c8_t  qpc [SQ_STEPS+1];
  sq_t  qpl [SQ_STEPS+1][2];
  c8_t  c8n;
  sq_t  q8n [2];
  c9_t  s9c, s10c, c9n;
  mpp_t s9m [5];
  mpp_t m9n [5];
  fx_t  s10v [5];

  logic signed [DATA_W-1:0] o_mass, o_momx, o_momy, o_energy;
  logic                     o_bad, o_sat;

  // stage 0 -> first multiply: state check, gamma-1, velocity squares, momenta, g*p
  fx_t rl0, rr0, ul0, ur0, wl0, wr0, pl0, pr0, gfx, gm1raw;

  always_comb begin
    rl0    = sx(s0.rl);
    rr0    = sx(s0.rr);
    ul0    = sx(s0.ul);
    ur0    = sx(s0.ur);
    wl0    = sx(s0.wl);
    wr0    = sx(s0.wr);
    pl0    = sx(s0.pl);
    pr0    = sx(s0.pr);
    gfx    = {{(64-GAMMA_W){1'b0}}, gamma};
    gm1raw = gfx - ONE_FX;
    c1n.bad = (rl0 <= fx_t'(0)) || (rr0 <= fx_t'(0)) || pl0[63] || pr0[63];
    // gamma not above one: use one lsb
    c1n.gm1 = (gm1raw <= fx_t'(0)) ? fx_t'(1) : gm1raw;
    c1n.rl  = rl0;
    c1n.rr  = rr0;
    c1n.ul  = ul0;
    c1n.ur  = ur0;
    c1n.pl  = pl0;
    c1n.pr  = pr0;
    m1n[M_UUL] = mul_pp(ul0, ul0);
    m1n[M_WWL] = mul_pp(wl0, wl0);
    m1n[M_UUR] = mul_pp(ur0, ur0);
    m1n[M_WWR] = mul_pp(wr0, wr0);
    m1n[M_MXL] = mul_pp(rl0, ul0);
    m1n[M_MXR] = mul_pp(rr0, ur0);
    m1n[M_MYL] = mul_pp(rl0, wl0);
    m1n[M_MYR] = mul_pp(rr0, wr0);
    m1n[M_GPL] = mul_pp(gfx, pl0);
    m1n[M_GPR] = mul_pp(gfx, pr0);
  end

  // star momenta, star density, kinetic terms
  fx_t kinl, kinr, mx2, my2;

  always_comb begin
    kinl = sadd(s2v[M_UUL], s2v[M_WWL]);
    kinr = sadd(s2v[M_UUR], s2v[M_WWR]);
    mx2  = half(sadd(s2v[M_MXL], s2v[M_MXR]));
    my2  = half(sadd(s2v[M_MYL], s2v[M_MYR]));
    c3n.bad = s2c.bad;
    c3n.gm1 = s2c.gm1;
    c3n.rl  = s2c.rl;
    c3n.rr  = s2c.rr;
    c3n.ul  = s2c.ul;
    c3n.ur  = s2c.ur;
    c3n.pl  = s2c.pl;
    c3n.pr  = s2c.pr;
    c3n.gpl = s2v[M_GPL];
    c3n.gpr = s2v[M_GPR];
    c3n.mx  = mx2;
    c3n.my  = my2;
    c3n.rs  = half(s2c.rl + s2c.rr);
    c3n.dmx = ssub(s2v[M_MXL], s2v[M_MXR]);
    c3n.dmy = ssub(s2v[M_MYL], s2v[M_MYR]);
    m3n[N_RKL] = mul_pp(s2c.rl, kinl);
    m3n[N_RKR] = mul_pp(s2c.rr, kinr);
    m3n[N_MXX] = mul_pp(mx2, mx2);
    m3n[N_MYY] = mul_pp(my2, my2);
    m3n[N_MXY] = mul_pp(my2, mx2);
  end

  // all eight divisions start together
  always_comb begin
    c5n.bad = s4c.bad;
    c5n.gm1 = s4c.gm1;
    c5n.rl  = s4c.rl;
    c5n.rr  = s4c.rr;
    c5n.ul  = s4c.ul;
    c5n.ur  = s4c.ur;
    c5n.mx  = s4c.mx;
    c5n.dmx = s4c.dmx;
    c5n.dmy = s4c.dmy;
    c5n.hkl = half(s4v[N_RKL]);
    c5n.hkr = half(s4v[N_RKR]);
    d5n[D_EPL] = div_init(s4c.pl, s4c.gm1);
    d5n[D_EPR] = div_init(s4c.pr, s4c.gm1);
    d5n[D_SSL] = div_init(s4c.gpl, s4c.rl);
    d5n[D_SSR] = div_init(s4c.gpr, s4c.rr);
    d5n[D_VX]  = div_init(s4c.mx, s4c.rs);
    d5n[D_FX]  = div_init(s4v[N_MXX], s4c.rs);
    d5n[D_FY]  = div_init(s4v[N_MXY], s4c.rs);
    d5n[D_Q]   = div_init(half(sadd(s4v[N_MXX], s4v[N_MYY])), s4c.rs);
  end

  // energies, star energy, star pressure operand
  fx_t el, er, es6;

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      dr[l] = div_fin(dpl[DIV_STEPS][l]);
    end
    el  = sadd(dr[D_EPL], dpc[DIV_STEPS].hkl);
    er  = sadd(dr[D_EPR], dpc[DIV_STEPS].hkr);
    es6 = half(sadd(el, er));
    c6n.bad = dpc[DIV_STEPS].bad;
    c6n.rl  = dpc[DIV_STEPS].rl;
    c6n.rr  = dpc[DIV_STEPS].rr;
    c6n.ul  = dpc[DIV_STEPS].ul;
    c6n.ur  = dpc[DIV_STEPS].ur;
    c6n.mx  = dpc[DIV_STEPS].mx;
    c6n.dmx = dpc[DIV_STEPS].dmx;
    c6n.dmy = dpc[DIV_STEPS].dmy;
    c6n.de  = ssub(el, er);
    c6n.es  = es6;
    c6n.dvx = dr[D_VX];
    c6n.dfx = dr[D_FX];
    c6n.dfy = dr[D_FY];
    m6n = mul_pp(dpc[DIV_STEPS].gm1, ssub(es6, dr[D_Q]));
  end

  // root operands ride with the pressure multiply
  fx_t ssl6, ssr6, dr_hold_l, dr_hold_r;

  // central x-momentum and energy terms, root operands g*p/rho
  always_comb begin
    c8n.bad = s7c.bad;
    c8n.rl  = s7c.rl;
    c8n.rr  = s7c.rr;
    c8n.ul  = s7c.ul;
    c8n.ur  = s7c.ur;
    c8n.mx  = s7c.mx;
    c8n.dmx = s7c.dmx;
    c8n.dmy = s7c.dmy;
    c8n.de  = s7c.de;
    c8n.dvx = s7c.dvx;
    c8n.dfy = s7c.dfy;
    c8n.fxc = sadd(s7c.dfx, s7p);
    c8n.ese = sadd(s7c.es, s7p);
    q8n[0]  = sq_init(dr_hold_l);
    q8n[1]  = sq_init(dr_hold_r);
  end

  // signal speeds and dissipation products
  fx_t cl, cr, hc;

  always_comb begin
    cl = sadd(fx_t'(qpl[SQ_STEPS][0].root), sabs(qpc[SQ_STEPS].ul));
    cr = sadd(fx_t'(qpl[SQ_STEPS][1].root), sabs(qpc[SQ_STEPS].ur));
    hc = half((cl > cr) ? cl : cr);
    c9n.bad = qpc[SQ_STEPS].bad;
    c9n.mx  = qpc[SQ_STEPS].mx;
    c9n.fxc = qpc[SQ_STEPS].fxc;
    c9n.dfy = qpc[SQ_STEPS].dfy;
    m9n[H_RHO] = mul_pp(hc, qpc[SQ_STEPS].rl - qpc[SQ_STEPS].rr);
    m9n[H_MX]  = mul_pp(hc, qpc[SQ_STEPS].dmx);
    m9n[H_MY]  = mul_pp(hc, qpc[SQ_STEPS].dmy);
    m9n[H_EN]  = mul_pp(hc, qpc[SQ_STEPS].de);
    m9n[H_FE]  = mul_pp(qpc[SQ_STEPS].dvx, qpc[SQ_STEPS].ese);
  end

  // final fluxes with clipping
  logic [DATA_W:0] km, kx, ky, ke;

  always_comb begin
    km = clip(ssub(s10c.mx, s10v[H_RHO]));
    kx = clip(ssub(s10c.fxc, s10v[H_MX]));
    ky = clip(ssub(s10c.dfy, s10v[H_MY]));
    ke = clip(ssub(s10v[H_FE], s10v[H_EN]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0.rl <= face.dens_left;
      s0.rr <= face.dens_right;
      s0.ul <= face.velx_left;
      s0.ur <= face.velx_right;
      s0.wl <= face.vely_left;
      s0.wr <= face.vely_right;
      s0.pl <= face.press_left;
      s0.pr <= face.press_right;

      s1c <= c1n;
      s2c <= s1c;
      for (int i = 0; i < 10; i++) begin
        s1m[i] <= m1n[i];
        s2v[i] <= mul_fin(s1m[i]);
      end

      s3c <= c3n;
      s4c <= s3c;
      for (int i = 0; i < 5; i++) begin
        s3m[i] <= m3n[i];
        s4v[i] <= mul_fin(s3m[i]);
      end

      dpc[0] <= c5n;
      for (int l = 0; l < 8; l++) begin
        dpl[0][l] <= d5n[l];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dpc[k+1] <= dpc[k];
        for (int l = 0; l < 8; l++) begin
          dpl[k+1][l] <= div_step(dpl[k][l]);
        end
      end

      s6c       <= c6n;
      s6m       <= m6n;
      ssl6      <= dr[D_SSL];
      ssr6      <= dr[D_SSR];
      s7c       <= s6c;
      s7p       <= mul_fin(s6m);
      dr_hold_l <= ssl6;
      dr_hold_r <= ssr6;

      qpc[0] <= c8n;
      for (int l = 0; l < 2; l++) begin
        qpl[0][l] <= q8n[l];
      end
      for (int k = 0; k < SQ_STEPS; k++) begin
        qpc[k+1] <= qpc[k];
        for (int l = 0; l < 2; l++) begin
          qpl[k+1][l] <= sq_step(qpl[k][l]);
        end
      end

      s9c  <= c9n;
      s10c <= s9c;
      for (int i = 0; i < 5; i++) begin
        s9m[i]  <= m9n[i];
        s10v[i] <= mul_fin(s9m[i]);
      end

      // bad state: all fluxes and the clip flag forced to zero
      o_bad    <= s10c.bad;
      o_mass   <= s10c.bad ? '0 : km[DATA_W-1:0];
      o_momx   <= s10c.bad ? '0 : kx[DATA_W-1:0];
      o_momy   <= s10c.bad ? '0 : ky[DATA_W-1:0];
      o_energy <= s10c.bad ? '0 : ke[DATA_W-1:0];
      o_sat    <= !s10c.bad && (km[DATA_W] || kx[DATA_W] || ky[DATA_W] || ke[DATA_W]);
    end
  end

  assign flux.valid       = vld[DEPTH-1];
  assign flux.mass_flux   = o_mass;
  assign flux.momx_flux   = o_momx;
  assign flux.momy_flux   = o_momy;
  assign flux.energy_flux = o_energy;
  assign flux.bad_state   = o_bad;
  assign flux.saturated   = o_sat;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    flux.valid && flux.bad_state |-> flux.mass_flux == '0 && flux.momx_flux == '0 &&
      flux.momy_flux == '0 && flux.energy_flux == '0 && !flux.saturated)
    else $error("bad state word carries nonzero flux");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    flux.valid && !flux.ready |-> !face.ready)
    else $error("face word taken while output held");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    face.valid && face.ready |=> vld[0])
    else $error("accepted face word lost at pipeline entry");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !flux.valid)
    else $error("output valid right after reset");

  a_rst_gamma: assert property (@(posedge clk)
    rst |=> gamma == GAMMA_RESET)
    else $error("gamma not at reset value");

endmodule

`default_nettype wire
